// ===== sv/assert_macros.svh =====
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/svcr_pkg.sv =====
// Types and constants of the SPI display memory command receiver.
package svcr_pkg;

	localparam int ADDR_BITS = 16;
	localparam int LEN_BITS  = 12;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN_LOW,
		PH_DATA,
		PH_ADDR_HIGH,
		PH_ADDR_LOW,
		PH_VC_LOW
	} phase_t;

	typedef enum logic [3:0] {
		CMD_SEQ_WRITE = 4'h1,
		CMD_SET_ADDR  = 4'h2,
		CMD_SET_MODE  = 4'h3,
		CMD_READ_LINE = 4'h4
	} cmd_t;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [LEN_BITS-1:0]  len_t;

endpackage

// ===== sv/svcr_in_if.sv =====
// Request channel: received SPI byte and live line counter.
interface svcr_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  mosi_byte;
	logic [15:0] line_count;

	modport source (output valid, output mosi_byte, output line_count, input ready);
	modport sink   (input valid, input mosi_byte, input line_count, output ready);
endinterface

// ===== sv/svcr_out_if.sv =====
// Result channel: memory write, display mode and reply byte.
interface svcr_out_if;
	logic        valid;
	logic        ready;
	logic        mem_write;
	logic [15:0] mem_address;
	logic [7:0]  mem_data;
	logic [3:0]  screen_mode;
	logic [7:0]  reply_byte;

	modport source (output valid, output mem_write, output mem_address, output mem_data,
		output screen_mode, output reply_byte, input ready);
	modport sink   (input valid, input mem_write, input mem_address, input mem_data,
		input screen_mode, input reply_byte, output ready);
endinterface

// ===== sv/spi_vram_command_receiver.sv =====
// Top level of the SPI display memory command receiver.
`include "assert_macros.svh"

// One result per received byte. A request is registered on acceptance and
// decoded against the command state into the result register once that
// register is free or being drained, so one byte per cycle is sustained while
// the result side accepts. The input register and the result register are
// separate, so a request is taken while a result waits if the input register is empty.
module spi_vram_command_receiver
	import svcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	svcr_in_if.sink     rx,
	svcr_out_if.source  tx
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] line_s1;

	// command state
	phase_t      phase_q, phase_d;
	addr_t       wptr_q, wptr_d;
	len_t        left_q, left_d;
	logic [3:0]  len_hi_q, len_hi_d;
	logic [7:0]  addr_hi_q, addr_hi_d;
	logic [15:0] line_q, line_d;
	logic [3:0]  mode_q, mode_d;

	// result register
	logic        tx_valid_q;
	logic        wr_q, wr_d;
	logic [15:0] waddr_q, waddr_d;
	logic [7:0]  wdata_q, wdata_d;
	logic [7:0]  reply_q, reply_d;

	logic        adv;
	len_t        len_new, left_dec;
	addr_t       addr_new;
	cmd_t        cmd;

	assign adv      = !tx_valid_q || tx.ready;
	assign rx.ready = !valid_s1 || adv;

	assign cmd      = cmd_t'(byte_s1[3:0]);
	assign len_new  = {len_hi_q, byte_s1};
	assign left_dec = left_q - len_t'(1);
	assign addr_new = addr_t'({addr_hi_q, byte_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.mosi_byte;
			line_s1 <= rx.line_count;
		end
	end

	// next phase
	always_comb begin
		phase_d = PH_IDLE;
		case (phase_q)
			PH_LEN_LOW:   phase_d = (len_new == '0) ? PH_IDLE : PH_DATA;
			PH_DATA:      phase_d = (left_dec == '0) ? PH_IDLE : PH_DATA;
			PH_ADDR_HIGH: phase_d = PH_ADDR_LOW;
			PH_ADDR_LOW:  phase_d = PH_IDLE;
			PH_VC_LOW:    phase_d = PH_IDLE;
			default: begin
				case (cmd)
					CMD_SEQ_WRITE: phase_d = PH_LEN_LOW;
					CMD_SET_ADDR:  phase_d = PH_ADDR_HIGH;
					CMD_READ_LINE: phase_d = PH_VC_LOW;
					default:       phase_d = PH_IDLE;
				endcase
			end
		endcase
	end

	// datapath and result
	always_comb begin
		wptr_d    = wptr_q;
		left_d    = left_q;
		len_hi_d  = len_hi_q;
		addr_hi_d = addr_hi_q;
		line_d    = line_q;
		mode_d    = mode_q;
		wr_d      = 1'b0;
		waddr_d   = 16'(wptr_q);
		wdata_d   = 8'h00;
		reply_d   = 8'h00;
		case (phase_q)
			PH_LEN_LOW: left_d = len_new;
			PH_DATA: begin
				wr_d    = 1'b1;
				wdata_d = byte_s1;
				wptr_d  = wptr_q + addr_t'(1);
				left_d  = left_dec;
			end
			PH_ADDR_HIGH: addr_hi_d = byte_s1;
			PH_ADDR_LOW: begin
				wptr_d  = addr_new;
				waddr_d = 16'(addr_new);
			end
			PH_VC_LOW: reply_d = line_q[7:0];
			default: begin
				case (cmd)
					CMD_SEQ_WRITE: len_hi_d = byte_s1[7:4];
					CMD_SET_MODE:  mode_d   = byte_s1[7:4];
					CMD_READ_LINE: begin
						line_d  = line_s1;
						reply_d = line_s1[15:8];
					end
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			wptr_q     <= '0;
			left_q     <= '0;
			len_hi_q   <= '0;
			addr_hi_q  <= '0;
			line_q     <= '0;
			mode_q     <= '0;
			tx_valid_q <= 1'b0;
		end else if (adv) begin
			tx_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q   <= phase_d;
				wptr_q    <= wptr_d;
				left_q    <= left_d;
				len_hi_q  <= len_hi_d;
				addr_hi_q <= addr_hi_d;
				line_q    <= line_d;
				mode_q    <= mode_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			wr_q    <= wr_d;
			waddr_q <= waddr_d;
			wdata_q <= wdata_d;
			reply_q <= reply_d;
		end
	end

	assign tx.valid       = tx_valid_q;
	assign tx.mem_write   = wr_q;
	assign tx.mem_address = waddr_q;
	assign tx.mem_data    = wdata_q;
	assign tx.screen_mode = mode_q;
	assign tx.reply_byte  = reply_q;

	`ASSERT_IMP(a_data_has_count, phase_q == PH_DATA, left_q != '0)
	`ASSERT_IMP(a_write_no_reply, tx_valid_q && wr_q, reply_q == 8'h00)
	`ASSERT_NEXT(a_s1_held, valid_s1 && !adv, valid_s1)
	`ASSERT_NEXT(a_accept_loads, rx.valid && rx.ready, valid_s1)

endmodule

// ===== tb/spi_vram_command_receiver_tb.sv =====
// Self-checking testbench for the SPI display memory command receiver.
`timescale 1ns / 1ps

module spi_vram_command_receiver_tb;
	import svcr_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_GAP     = 17;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 650;
	localparam int LONG_LEN    = 400;

	typedef struct packed {
		logic       mem_write;
		addr_t      mem_address;
		logic [7:0] mem_data;
		logic [3:0] screen_mode;
		logic [7:0] reply_byte;
	} result_t;

	logic clk;
	logic arst_n;

	svcr_in_if  rx_if();
	svcr_out_if tx_if();

	spi_vram_command_receiver u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	// predicted receiver state
	phase_t     cur_phase;
	addr_t      wr_ptr;
	len_t       remaining;
	logic [3:0] len_hi;
	logic [7:0] addr_hi;
	logic [15:0] line_latch;
	logic [3:0] mode;

	result_t expected_q[$];
	int      errors;
	int      cycle_count;
	int      hold_request;
	bit      quiet;
	bit      burst;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, expected_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] rand_line();
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic result_t decode_byte(input logic [7:0] b, input logic [15:0] line);
		result_t r;
		r.mem_write   = 1'b0;
		r.mem_address = wr_ptr;
		r.mem_data    = 8'h00;
		r.reply_byte  = 8'h00;
		case (cur_phase)
			PH_LEN_LOW: begin
				remaining = {len_hi, b};
				cur_phase = (remaining == '0) ? PH_IDLE : PH_DATA;
			end
			PH_DATA: begin
				r.mem_write = 1'b1;
				r.mem_data  = b;
				wr_ptr      = wr_ptr + 1'b1;
				remaining   = remaining - 1'b1;
				if (remaining == '0)
					cur_phase = PH_IDLE;
			end
			PH_ADDR_HIGH: begin
				addr_hi   = b;
				cur_phase = PH_ADDR_LOW;
			end
			PH_ADDR_LOW: begin
				wr_ptr        = {addr_hi, b};
				r.mem_address = wr_ptr;
				cur_phase     = PH_IDLE;
			end
			PH_VC_LOW: begin
				r.reply_byte = line_latch[7:0];
				cur_phase    = PH_IDLE;
			end
			default: begin
				cur_phase = PH_IDLE;
				case (b[3:0])
					CMD_SEQ_WRITE: begin
						len_hi    = b[7:4];
						cur_phase = PH_LEN_LOW;
					end
					CMD_SET_ADDR: cur_phase = PH_ADDR_HIGH;
					CMD_SET_MODE: mode = b[7:4];
					CMD_READ_LINE: begin
						line_latch   = line;
						r.reply_byte = line[15:8];
						cur_phase    = PH_VC_LOW;
					end
					default: ;
				endcase
			end
		endcase
		r.screen_mode = mode;
		return r;
	endfunction

	task automatic send_request(input logic [7:0] b, input logic [15:0] line);
		int gap;
		gap = (quiet || burst) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid      <= 1'b1;
		rx_if.mosi_byte  <= b;
		rx_if.line_count <= line;
		do @(posedge clk); while (!rx_if.ready);
		expected_q.push_back(decode_byte(b, line));
	endtask

	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && tx_if.valid && tx_if.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request pending, expected none got 0x%0h",
					$time, {tx_if.mem_write, tx_if.mem_address, tx_if.mem_data,
					tx_if.screen_mode, tx_if.reply_byte});
				errors++;
			end else begin
				want = expected_q.pop_front();
				check_field("mem_write", 16'(want.mem_write), 16'(tx_if.mem_write));
				check_field("mem_address", want.mem_address, tx_if.mem_address);
				check_field("mem_data", 16'(want.mem_data), 16'(tx_if.mem_data));
				check_field("screen_mode", 16'(want.screen_mode), 16'(tx_if.screen_mode));
				check_field("reply_byte", 16'(want.reply_byte), 16'(tx_if.reply_byte));
			end
		end
	end

	initial begin : result_sink
		int stall;
		tx_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else if (quiet) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, MAX_GAP);
			end
			if (stall > 0) begin
				tx_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tx_if.ready <= 1'b1;
			do @(posedge clk); while (!(tx_if.valid && tx_if.ready));
		end
	end

	task automatic test_ignored_commands();
		send_request(8'h00, 16'h0000);
		send_request(8'hFF, 16'hFFFF);
		send_request(8'h05, 16'h0000);
		send_request(8'hA0, 16'hFFFF);
		send_request(8'h5E, 16'h0000);
	endtask

	task automatic test_mode_select();
		send_request({4'hF, CMD_SET_MODE}, 16'hFFFF);
		send_request({4'h0, CMD_SET_MODE}, 16'h0000);
		send_request({4'h1, CMD_SET_MODE}, 16'hFFFF);
		send_request({4'h2, CMD_SET_MODE}, 16'h0000);
	endtask

	task automatic test_address_wrap();
		send_request({4'hF, CMD_SET_ADDR}, 16'h0000);
		send_request(8'hFF, 16'hFFFF);
		send_request(8'hFF, 16'h0000);
		send_request({4'h0, CMD_SEQ_WRITE}, 16'hFFFF);
		send_request(8'h03, 16'h0000);
		send_request(8'hFF, 16'hFFFF);
		send_request(8'h00, 16'h0000);
		send_request(8'h5A, 16'hA5A5);
	endtask

	task automatic test_zero_length();
		send_request({4'h0, CMD_SEQ_WRITE}, 16'h0000);
		send_request(8'h00, 16'hFFFF);
		send_request({4'h1, CMD_SET_MODE}, 16'h0000);
	endtask

	task automatic test_line_latch();
		send_request({4'hF, CMD_READ_LINE}, 16'hFFFF);
		send_request({4'h0, CMD_SEQ_WRITE}, 16'h0000);
		send_request({4'h0, CMD_READ_LINE}, 16'h0000);
		send_request(8'hFF, 16'h1234);
		send_request(8'h00, 16'hFFFF);
	endtask

	// long write streamed at full rate while the result side holds off
	task automatic test_long_write_backpressure();
		logic [11:0] len;
		len = 12'(LONG_LEN);
		send_request({4'h0, CMD_SET_ADDR}, rand_line());
		send_request(rand_byte(), rand_line());
		send_request(rand_byte(), rand_line());
		send_request({len[11:8], CMD_SEQ_WRITE}, rand_line());
		send_request(len[7:0], rand_line());
		burst = 1'b1;
		hold_request = HOLD_CYCLES;
		repeat (LONG_LEN) send_request(rand_byte(), rand_line());
		burst = 1'b0;
	endtask

	task automatic send_random_command(output int counted);
		int kind;
		int pick;
		int len;
		logic [3:0] nib;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		nib  = 4'($urandom_range(0, 15));
		if (kind < 45) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				len = $urandom_range(0, 12);
			else if (pick < 97)
				len = $urandom_range(13, 255);
			else
				len = $urandom_range(256, 700);
			send_request({len[11:8], CMD_SEQ_WRITE}, rand_line());
			send_request(len[7:0], rand_line());
			repeat (len) send_request(rand_byte(), rand_line());
			counted = 2 + len;
		end else if (kind < 60) begin
			send_request({nib, CMD_SET_ADDR}, rand_line());
			send_request(rand_byte(), rand_line());
			send_request(rand_byte(), rand_line());
			counted = 3;
		end else if (kind < 72) begin
			send_request({nib, CMD_SET_MODE}, rand_line());
			counted = 1;
		end else if (kind < 88) begin
			send_request({nib, CMD_READ_LINE}, rand_line());
			send_request(rand_byte(), rand_line());
			counted = 2;
		end else begin
			b = rand_byte();
			while (b[3:0] inside {CMD_SEQ_WRITE, CMD_SET_ADDR, CMD_SET_MODE, CMD_READ_LINE})
				b = rand_byte();
			send_request(b, rand_line());
			counted = 1;
		end
	endtask

	task automatic test_random_traffic();
		int done;
		int n;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			if ($urandom_range(0, 49) == 0)
				quiet = ~quiet;
			if ($urandom_range(0, 99) == 0)
				wait_drained();
			send_random_command(n);
			done += n;
		end
		quiet = 1'b0;
	endtask

	task automatic test_idle_pause();
		int n;
		wait_drained();
		repeat (20) @(posedge clk);
		repeat (10) send_random_command(n);
	endtask

	initial begin
		arst_n           <= 1'b0;
		rx_if.valid      <= 1'b0;
		rx_if.mosi_byte  <= 8'h00;
		rx_if.line_count <= 16'h0000;
		errors       = 0;
		cycle_count  = 0;
		hold_request = 0;
		quiet        = 1'b0;
		burst        = 1'b0;
		cur_phase    = PH_IDLE;
		wr_ptr       = '0;
		remaining    = '0;
		len_hi       = 4'h0;
		addr_hi      = 8'h00;
		line_latch   = 16'h0000;
		mode         = 4'h0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_ignored_commands();
		test_mode_select();
		test_address_wrap();
		test_zero_length();
		test_line_latch();
		test_long_write_backpressure();
		test_idle_pause();
		test_random_traffic();
		test_idle_pause();

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_q.size());
			errors++;
		end
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/svcr_pkg.sv
sv/svcr_in_if.sv
sv/svcr_out_if.sv
sv/spi_vram_command_receiver.sv
tb/spi_vram_command_receiver_tb.sv
